[src/right_hand_maze_walker_core_macros.svh]
// assertion helpers, all sampled on clk and muted while rst_n is low
`ifndef RIGHT_HAND_MAZE_WALKER_CORE_MACROS_SVH
`define RIGHT_HAND_MAZE_WALKER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RHMW_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define RHMW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define RHMW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define RHMW_ASSERT_ALWAYS(lbl, cond, msg)
`define RHMW_ASSERT_IMPL(lbl, ante, cons, msg)
`define RHMW_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[src/rhmw_pkg.sv]
`default_nettype none

package rhmw_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] HEAD_N = 2'd0;
  localparam logic [1:0] HEAD_S = 2'd1;
  localparam logic [1:0] HEAD_W = 2'd2;
  localparam logic [1:0] HEAD_E = 2'd3;

  localparam logic [1:0] ST_MOVED = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_NOENT = 2'd2;

  // order in which the walker tries its neighbours
  localparam logic [1:0] TRY_RIGHT    = 2'd0;
  localparam logic [1:0] TRY_STRAIGHT = 2'd1;
  localparam logic [1:0] TRY_LEFT     = 2'd2;
  localparam logic [1:0] TRY_BACK     = 2'd3;

  // first member sits in the top bits, so pos_row lands in the lowest bits
  typedef struct packed {
    logic       cell_visited;
    logic       cell_wall;
    logic [1:0] status;
    logic [1:0] heading;
    logic [3:0] pos_col;
    logic [3:0] pos_row;
  } res_t;

  function automatic logic [1:0] right_of(input logic [1:0] h);
    logic [1:0] r;
    case (h)
      HEAD_N:  r = HEAD_E;
      HEAD_S:  r = HEAD_W;
      HEAD_W:  r = HEAD_N;
      default: r = HEAD_S;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] left_of(input logic [1:0] h);
    logic [1:0] r;
    case (h)
      HEAD_N:  r = HEAD_W;
      HEAD_S:  r = HEAD_E;
      HEAD_W:  r = HEAD_S;
      default: r = HEAD_N;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] back_of(input logic [1:0] h);
    logic [1:0] r;
    case (h)
      HEAD_N:  r = HEAD_S;
      HEAD_S:  r = HEAD_N;
      HEAD_W:  r = HEAD_E;
      default: r = HEAD_W;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cand_dir(input logic [1:0] h, input logic [1:0] t);
    logic [1:0] r;
    case (t)
      TRY_RIGHT:    r = right_of(h);
      TRY_STRAIGHT: r = h;
      TRY_LEFT:     r = left_of(h);
      default:      r = back_of(h);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[src/rhmw_ram.sv]
`default_nettype none

module rhmw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

[src/rhmw_ctrl.sv]
`default_nettype none

`include "right_hand_maze_walker_core_macros.svh"

module rhmw_ctrl #(
  parameter int GRID_SIZE = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic [1:0]                              in_op,
  input  wire logic [3:0]                              in_row,
  input  wire logic [3:0]                              in_col,
  input  wire logic                                    in_wall,
  output logic                                         wall_en,
  output logic                                         wall_we,
  output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]       wall_addr,
  output logic                                         wall_wdata,
  input  wire logic                                    wall_rdata,
  output logic                                         vis_en,
  output logic                                         vis_we,
  output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]       vis_addr,
  output logic                                         vis_wdata,
  input  wire logic                                    vis_rdata,
  input  wire logic                                    out_free,
  output logic                                         res_valid,
  output rhmw_pkg::res_t                               res
);

  localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = $clog2(GRID_SIZE);
  localparam logic [POS_W-1:0]  LAST     = POS_W'(GRID_SIZE - 1);
  localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(DEPTH - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_PROBE = 5'b00100,
    S_CHECK = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                 state_r,     state_nxt;
  logic [ADDR_W-1:0]      clr_cnt_r,   clr_cnt_nxt;
  logic [POS_W-1:0]       pos_row_r,   pos_row_nxt;
  logic [POS_W-1:0]       pos_col_r,   pos_col_nxt;
  logic [1:0]             head_r,      head_nxt;
  logic                   started_r,   started_nxt;
  logic                   done_r,      done_nxt;
  logic [GRID_SIZE-1:0]   col0_open_r, col0_open_nxt;
  logic [1:0]             try_r,       try_nxt;
  logic [1:0]             status_r,    status_nxt;
  logic                   is_read_r,   is_read_nxt;
  logic                   rd_inside_r, rd_inside_nxt;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] r,
                                                  input logic [POS_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(GRID_SIZE)) + ADDR_W'(c);
  endfunction

  // entrance: lowest open row of column 0, by isolating the lowest set bit
  logic [GRID_SIZE-1:0] ent_onehot;
  logic [POS_W-1:0]     ent_row;
  logic                 ent_valid;

  always_comb begin
    ent_onehot = col0_open_r & (~col0_open_r + GRID_SIZE'(1));
    ent_valid  = |col0_open_r;
    ent_row    = '0;
    for (int i = 0; i < GRID_SIZE; i++) begin
      if (ent_onehot[i]) begin
        ent_row = ent_row | POS_W'(i);
      end
    end
  end

  // neighbour in the direction currently tried
  logic [1:0]       cand;
  logic             nb_out;
  logic [POS_W-1:0] nb_row;
  logic [POS_W-1:0] nb_col;

  always_comb begin
    cand   = rhmw_pkg::cand_dir(head_r, try_r);
    nb_row = pos_row_r;
    nb_col = pos_col_r;
    case (cand)
      rhmw_pkg::HEAD_N: begin
        nb_out = (pos_row_r == '0);
        nb_row = pos_row_r - POS_W'(1);
      end
      rhmw_pkg::HEAD_S: begin
        nb_out = (pos_row_r == LAST);
        nb_row = pos_row_r + POS_W'(1);
      end
      rhmw_pkg::HEAD_W: begin
        nb_out = (pos_col_r == '0);
        nb_col = pos_col_r - POS_W'(1);
      end
      default: begin
        nb_out = (pos_col_r == LAST);
        nb_col = pos_col_r + POS_W'(1);
      end
    endcase
  end

  logic              in_inside;
  logic [POS_W-1:0]  in_r;
  logic [POS_W-1:0]  in_c;
  logic [ADDR_W-1:0] in_addr;
  logic              finish;
  logic              at_edge;

  always_comb begin
    in_inside = (32'(in_row) < 32'(GRID_SIZE)) && (32'(in_col) < 32'(GRID_SIZE));
    in_r      = POS_W'(in_row);
    in_c      = POS_W'(in_col);
    in_addr   = cell_addr(in_r, in_c);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    pos_row_nxt   = pos_row_r;
    pos_col_nxt   = pos_col_r;
    head_nxt      = head_r;
    started_nxt   = started_r;
    done_nxt      = done_r;
    col0_open_nxt = col0_open_r;
    try_nxt       = try_r;
    status_nxt    = status_r;
    is_read_nxt   = is_read_r;
    rd_inside_nxt = rd_inside_r;
    wall_en       = 1'b0;
    wall_we       = 1'b0;
    wall_addr     = in_addr;
    wall_wdata    = in_wall;
    vis_en        = 1'b0;
    vis_we        = 1'b0;
    vis_addr      = in_addr;
    vis_wdata     = 1'b0;
    res_valid     = 1'b0;
    finish        = 1'b0;
    in_ready      = (state_r == S_IDLE);

    case (state_r)
      S_CLEAR: begin
        vis_en      = 1'b1;
        vis_we      = 1'b1;
        vis_addr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == LAST_ADR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            rhmw_pkg::OP_LOAD: begin
              if (in_inside) begin
                wall_en = 1'b1;
                wall_we = 1'b1;
                vis_en  = 1'b1;
                vis_we  = 1'b1;
                if (in_c == '0) begin
                  col0_open_nxt[in_r] = !in_wall;
                end
              end
            end
            rhmw_pkg::OP_STEP: begin
              is_read_nxt = 1'b0;
              state_nxt   = S_EMIT;
              if (!started_r) begin
                if (!ent_valid) begin
                  status_nxt = rhmw_pkg::ST_NOENT;
                end else begin
                  started_nxt = 1'b1;
                  pos_row_nxt = ent_row;
                  pos_col_nxt = '0;
                  head_nxt    = rhmw_pkg::HEAD_E;
                  status_nxt  = rhmw_pkg::ST_MOVED;
                  vis_en      = 1'b1;
                  vis_we      = 1'b1;
                  vis_wdata   = 1'b1;
                  vis_addr    = cell_addr(ent_row, '0);
                end
              end else if (done_r) begin
                status_nxt = rhmw_pkg::ST_DONE;
              end else begin
                try_nxt   = rhmw_pkg::TRY_RIGHT;
                state_nxt = S_PROBE;
              end
            end
            rhmw_pkg::OP_READ: begin
              wall_en       = 1'b1;
              vis_en        = 1'b1;
              is_read_nxt   = 1'b1;
              rd_inside_nxt = in_inside;
              status_nxt    = rhmw_pkg::ST_MOVED;
              state_nxt     = S_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      S_PROBE: begin
        if (try_r == rhmw_pkg::TRY_BACK) begin
          // turning back steps even into a wall, but never off the grid
          head_nxt = cand;
          finish   = 1'b1;
          if (!nb_out) begin
            pos_row_nxt = nb_row;
            pos_col_nxt = nb_col;
            vis_en      = 1'b1;
            vis_we      = 1'b1;
            vis_wdata   = 1'b1;
            vis_addr    = cell_addr(nb_row, nb_col);
          end
        end else if (nb_out) begin
          try_nxt = try_r + 2'd1;
        end else begin
          wall_en   = 1'b1;
          wall_addr = cell_addr(nb_row, nb_col);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!wall_rdata) begin
          head_nxt    = cand;
          pos_row_nxt = nb_row;
          pos_col_nxt = nb_col;
          vis_en      = 1'b1;
          vis_we      = 1'b1;
          vis_wdata   = 1'b1;
          vis_addr    = cell_addr(nb_row, nb_col);
          finish      = 1'b1;
        end else begin
          try_nxt   = try_r + 2'd1;
          state_nxt = S_PROBE;
        end
      end
      S_EMIT: begin
        res_valid = 1'b1;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    at_edge = (pos_row_nxt == LAST) || (pos_col_nxt == LAST);
    if (finish) begin
      done_nxt   = at_edge;
      status_nxt = at_edge ? rhmw_pkg::ST_DONE : rhmw_pkg::ST_MOVED;
      state_nxt  = S_EMIT;
    end
  end

  always_comb begin
    res.pos_row      = 4'(pos_row_r);
    res.pos_col      = 4'(pos_col_r);
    res.heading      = head_r;
    res.status       = status_r;
    res.cell_wall    = is_read_r && rd_inside_r && wall_rdata;
    res.cell_visited = is_read_r && rd_inside_r && vis_rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pos_row_r   <= '0;
      pos_col_r   <= '0;
      head_r      <= rhmw_pkg::HEAD_E;
      started_r   <= 1'b0;
      done_r      <= 1'b0;
      col0_open_r <= '0;
      try_r       <= rhmw_pkg::TRY_RIGHT;
      status_r    <= rhmw_pkg::ST_MOVED;
      is_read_r   <= 1'b0;
      rd_inside_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pos_row_r   <= pos_row_nxt;
      pos_col_r   <= pos_col_nxt;
      head_r      <= head_nxt;
      started_r   <= started_nxt;
      done_r      <= done_nxt;
      col0_open_r <= col0_open_nxt;
      try_r       <= try_nxt;
      status_r    <= status_nxt;
      is_read_r   <= is_read_nxt;
      rd_inside_r <= rd_inside_nxt;
    end
  end

  `RHMW_ASSERT_IMPL(a_done_needs_start, done_r, started_r, "walk done before it started")
  `RHMW_ASSERT_NEXT(a_done_holds_pos, done_r, $stable(pos_row_r) && $stable(pos_col_r), "walker moved after done")
  `RHMW_ASSERT_IMPL(a_check_not_back, state_r == S_CHECK, try_r != rhmw_pkg::TRY_BACK, "wall check on the turn-back try")
  `RHMW_ASSERT_ALWAYS(a_wall_one_access, !(wall_we && (state_r == S_PROBE || state_r == S_CHECK)), "map write during a probe")

endmodule

`default_nettype wire

[src/right_hand_maze_walker_core.sv]
// right-hand wall-follower maze walker
// input channel in_*: one beat is one command, in_tuser carries the opcode
//   load cell: writes the wall bit, clears the visited mark, no result beat
//   step: advances the walker one move, one result beat
//   read cell: reports wall bit and visited mark of one cell, one result beat
// result channel out_*: walker position, heading, status and cell bits
// a read, and a step in the first, done or no-entrance case, go straight to
//   the result; any other step makes up to three wall probes through the
//   single-port wall map (each issued, then checked) before the final move
// a load writes the maps and returns to idle; one command is in flight at a time
// after reset the visited map is swept clear, cell by cell, with in_tready
// low; the wall map holds nothing until cells are loaded
// a stalled receiver holds the result in the output register; the core
// still takes further commands and only waits when a second result is ready
`default_nettype none

module right_hand_maze_walker_core #(
  parameter int GRID_SIZE = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // row[3:0], col[7:4], wall[8], zero pad
  input  wire logic [1:0]  in_tuser,  // op[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata  // pos_row[3:0], pos_col[7:4], heading[9:8],
                                      // status[11:10], cell_wall[12],
                                      // cell_visited[13], zero pad
);

  localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              wall_en;
  logic              wall_we;
  logic [ADDR_W-1:0] wall_addr;
  logic              wall_wdata;
  logic              wall_rdata;
  logic              vis_en;
  logic              vis_we;
  logic [ADDR_W-1:0] vis_addr;
  logic              vis_wdata;
  logic              vis_rdata;
  logic              out_free;
  logic              res_valid;
  rhmw_pkg::res_t    res;

  logic              out_valid_r, out_valid_nxt;
  rhmw_pkg::res_t    out_res_r,   out_res_nxt;

  rhmw_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_wall_ram (
    .clk   (clk),
    .en    (wall_en),
    .we    (wall_we),
    .addr  (wall_addr),
    .wdata (wall_wdata),
    .rdata (wall_rdata)
  );

  rhmw_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_vis_ram (
    .clk   (clk),
    .en    (vis_en),
    .we    (vis_we),
    .addr  (vis_addr),
    .wdata (vis_wdata),
    .rdata (vis_rdata)
  );

  rhmw_ctrl #(
    .GRID_SIZE (GRID_SIZE)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_row     (in_tdata[3:0]),
    .in_col     (in_tdata[7:4]),
    .in_wall    (in_tdata[8]),
    .wall_en    (wall_en),
    .wall_we    (wall_we),
    .wall_addr  (wall_addr),
    .wall_wdata (wall_wdata),
    .wall_rdata (wall_rdata),
    .vis_en     (vis_en),
    .vis_we     (vis_we),
    .vis_addr   (vis_addr),
    .vis_wdata  (vis_wdata),
    .vis_rdata  (vis_rdata),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register, free when empty or emptied in this cycle
  always_comb begin
    out_free      = !out_valid_r || out_tready;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    if (res_valid && out_free) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

endmodule

`default_nettype wire

[tb/tb_right_hand_maze_walker_core.sv]
`default_nettype none

module tb_right_hand_maze_walker_core;

  localparam int GRID = 16;
  localparam int HOLD_CYCLES = 80;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // quarter turns clockwise from the current heading
  localparam int QTR_AHEAD = 0;
  localparam int QTR_RIGHT = 1;
  localparam int QTR_BACK  = 2;
  localparam int QTR_LEFT  = 3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // row[3:0], col[7:4], wall[8], zero pad
  logic [1:0]  in_tuser;   // op[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // pos_row[3:0], pos_col[7:4], heading[9:8], status[11:10],
                           // cell_wall[12], cell_visited[13], zero pad

  right_hand_maze_walker_core #(
    .GRID_SIZE(GRID)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // walker state as the design should hold it
  bit         wall_grid  [GRID][GRID];
  bit         visit_grid [GRID][GRID];
  logic [15:0] col0_open = '0;
  logic [3:0] wk_row     = '0;
  logic [3:0] wk_col     = '0;
  logic [1:0] wk_head    = rhmw_pkg::HEAD_E;
  bit         wk_started = 1'b0;
  bit         wk_done    = 1'b0;

  rhmw_pkg::res_t walker_reports [$];
  rhmw_pkg::res_t got;
  rhmw_pkg::res_t want;
  int   mismatch_count = 0;
  bit   idle_off = 1'b0;
  bit   hold_req = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [1:0] turn(input logic [1:0] h, input int quarters);
    int idx;
    logic [1:0] res;
    case (h)
      rhmw_pkg::HEAD_N: idx = 0;
      rhmw_pkg::HEAD_E: idx = 1;
      rhmw_pkg::HEAD_S: idx = 2;
      default:          idx = 3;
    endcase
    case ((idx + quarters) % 4)
      0:       res = rhmw_pkg::HEAD_N;
      1:       res = rhmw_pkg::HEAD_E;
      2:       res = rhmw_pkg::HEAD_S;
      default: res = rhmw_pkg::HEAD_W;
    endcase
    return res;
  endfunction

  // update the walker state for one accepted beat and queue the report it causes
  function automatic void account(input logic [1:0] op, input logic [3:0] r,
                                  input logic [3:0] c, input logic w);
    rhmw_pkg::res_t rep;
    logic [1:0] h;
    logic [1:0] d;
    bit moved;
    int k, q, rr, cc, ent;
    rep = '0;
    ent = 0;
    case (op)
      rhmw_pkg::OP_LOAD: begin
        wall_grid[r][c] = w;
        visit_grid[r][c] = 1'b0;
        if (c == 4'd0) col0_open[r] = ~w;
      end
      rhmw_pkg::OP_STEP: begin
        h = wk_head;
        if (!wk_started) begin
          if (col0_open == '0) begin
            rep.status = rhmw_pkg::ST_NOENT;
          end else begin
            for (k = GRID - 1; k >= 0; k--) if (col0_open[k]) ent = k;
            wk_started = 1'b1;
            wk_row = ent[3:0];
            wk_col = 4'd0;
            wk_head = rhmw_pkg::HEAD_E;
            visit_grid[ent][0] = 1'b1;
            rep.status = rhmw_pkg::ST_MOVED;
          end
        end else if (wk_done) begin
          rep.status = rhmw_pkg::ST_DONE;
        end else begin
          moved = 1'b0;
          // right, ahead, left must be open; turning back takes any cell inside
          for (k = 0; k < 4; k++) begin
            q = (k == 0) ? QTR_RIGHT : (k == 1) ? QTR_AHEAD : (k == 2) ? QTR_LEFT : QTR_BACK;
            d = turn(h, q);
            rr = int'(wk_row);
            cc = int'(wk_col);
            case (d)
              rhmw_pkg::HEAD_N: rr = rr - 1;
              rhmw_pkg::HEAD_S: rr = rr + 1;
              rhmw_pkg::HEAD_W: cc = cc - 1;
              default:          cc = cc + 1;
            endcase
            if (!moved && rr >= 0 && rr < GRID && cc >= 0 && cc < GRID) begin
              if (k == 3 || !wall_grid[rr][cc]) begin
                wk_row = rr[3:0];
                wk_col = cc[3:0];
                wk_head = d;
                visit_grid[rr][cc] = 1'b1;
                moved = 1'b1;
              end
            end
          end
          if (!moved) wk_head = turn(h, QTR_BACK);
          if (wk_row == GRID - 1 || wk_col == GRID - 1) begin
            wk_done = 1'b1;
            rep.status = rhmw_pkg::ST_DONE;
          end else begin
            rep.status = rhmw_pkg::ST_MOVED;
          end
        end
      end
      rhmw_pkg::OP_READ: begin
        rep.cell_wall = wall_grid[r][c];
        rep.cell_visited = visit_grid[r][c];
      end
      default: ;
    endcase
    if (op == rhmw_pkg::OP_STEP || op == rhmw_pkg::OP_READ) begin
      rep.pos_row = wk_row;
      rep.pos_col = wk_col;
      rep.heading = wk_head;
      walker_reports.push_back(rep);
    end
  endfunction

  task automatic send_cmd(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c,
                          input logic w);
    int gap;
    gap = 0;
    if (!idle_off && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, w, c, r};
    do @(posedge clk); while (in_tready !== 1'b1);
    account(op, r, c, w);
  endtask

  task automatic report_mismatch(input string what, input int got_val, input int want_val);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got_val, want_val, $time);
  endtask

  // steps with no entrance, an ignored opcode and a walled column-0 cell
  task automatic test_before_entrance();
    send_cmd(rhmw_pkg::OP_STEP, 4'hf, 4'hf, 1'b1);
    send_cmd(OP_UNUSED, 4'hf, 4'hf, 1'b1);
    send_cmd(rhmw_pkg::OP_LOAD, 4'd0, 4'd0, 1'b1);
    send_cmd(rhmw_pkg::OP_STEP, 4'd0, 4'd0, 1'b0);
    send_cmd(rhmw_pkg::OP_READ, 4'd0, 4'd0, 1'b0);
  endtask

  // every cell loaded; border of last row and column kept as walls
  task automatic test_fill_maze();
    int r, c;
    logic w;
    for (r = 0; r < GRID; r++) begin
      for (c = 0; c < GRID; c++) begin
        if (c == 0) w = !(r == 2 || r == 6 || r == 9);
        else if (r == GRID - 1 || c == GRID - 1 || (r == 2 && c == 1)) w = 1'b1;
        else w = ($urandom_range(0, 99) < 35);
        send_cmd(rhmw_pkg::OP_LOAD, r[3:0], c[3:0], w);
      end
    end
  endtask

  // lowest open row wins; the entrance cell is boxed in so the walker turns round
  // at the grid edge and then backs into a wall cell
  task automatic test_dead_end();
    send_cmd(rhmw_pkg::OP_LOAD, 4'd1, 4'd0, 1'b0);
    send_cmd(rhmw_pkg::OP_LOAD, 4'd1, 4'd0, 1'b1);
    send_cmd(rhmw_pkg::OP_STEP, 4'd0, 4'd0, 1'b0);
    send_cmd(rhmw_pkg::OP_STEP, 4'd0, 4'd0, 1'b0);
    send_cmd(rhmw_pkg::OP_STEP, 4'd0, 4'd0, 1'b0);
    send_cmd(rhmw_pkg::OP_READ, 4'd2, 4'd0, 1'b0);
    send_cmd(rhmw_pkg::OP_READ, 4'd2, 4'd1, 1'b0);
    send_cmd(rhmw_pkg::OP_LOAD, 4'd2, 4'd1, 1'b0);
    send_cmd(rhmw_pkg::OP_READ, 4'd2, 4'd1, 1'b0);
    send_cmd(rhmw_pkg::OP_LOAD, 4'd2, 4'd2, 1'b0);
    send_cmd(rhmw_pkg::OP_STEP, 4'd0, 4'd0, 1'b0);
    send_cmd(rhmw_pkg::OP_STEP, 4'd0, 4'd0, 1'b0);
  endtask

  task automatic test_result_hold();
    int n;
    hold_req = 1'b1;
    for (n = 0; n < 14; n++)
      send_cmd(n[0] ? rhmw_pkg::OP_READ : rhmw_pkg::OP_STEP, 4'($urandom_range(0, GRID - 1)),
               4'($urandom_range(0, GRID - 1)), 1'($urandom_range(0, 1)));
  endtask

  // walk with cells around the walker reloaded now and then
  task automatic test_random_walk(input int count);
    int n, pick, rr, cc;
    logic w;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 1)) begin
        rr = int'(wk_row);
        cc = int'(wk_col);
        rr = rr + $urandom_range(0, 2) - 1;
        cc = cc + $urandom_range(0, 2) - 1;
        if (rr < 0) rr = 0;
        if (cc < 0) cc = 0;
        if (rr > GRID - 1) rr = GRID - 1;
        if (cc > GRID - 1) cc = GRID - 1;
      end else begin
        rr = $urandom_range(0, GRID - 1);
        cc = $urandom_range(0, GRID - 1);
      end
      if (pick < 55) begin
        send_cmd(rhmw_pkg::OP_STEP, rr[3:0], cc[3:0], 1'($urandom_range(0, 1)));
      end else if (pick < 75) begin
        send_cmd(rhmw_pkg::OP_READ, rr[3:0], cc[3:0], 1'($urandom_range(0, 1)));
      end else if (pick < 97) begin
        // far edge stays walled so the walk does not end early
        w = (rr == GRID - 1 || cc == GRID - 1) ? 1'b1 : ($urandom_range(0, 99) < 40);
        send_cmd(rhmw_pkg::OP_LOAD, rr[3:0], cc[3:0], w);
      end else begin
        send_cmd(OP_UNUSED, rr[3:0], cc[3:0], 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // open a corridor along the walker's row out to the last column
  task automatic test_reach_edge();
    int k, guard;
    logic [3:0] lane;
    lane = wk_row;
    for (k = 0; k < GRID; k++) begin
      if (lane > 0) send_cmd(rhmw_pkg::OP_LOAD, lane - 4'd1, k[3:0], 1'b1);
      if (lane < GRID - 1) send_cmd(rhmw_pkg::OP_LOAD, lane + 4'd1, k[3:0], 1'b1);
      send_cmd(rhmw_pkg::OP_LOAD, lane, k[3:0], 1'b0);
    end
    guard = 0;
    while (!wk_done && guard < 4 * GRID) begin
      send_cmd(rhmw_pkg::OP_STEP, 4'($urandom_range(0, GRID - 1)),
               4'($urandom_range(0, GRID - 1)), 1'b0);
      guard++;
    end
    send_cmd(rhmw_pkg::OP_STEP, 4'd0, 4'd0, 1'b0);
    send_cmd(rhmw_pkg::OP_STEP, 4'd0, 4'd0, 1'b0);
    send_cmd(rhmw_pkg::OP_READ, lane, 4'(GRID - 1), 1'b0);
    send_cmd(rhmw_pkg::OP_READ, lane, 4'd0, 1'b0);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = rhmw_pkg::OP_LOAD;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_before_entrance();
    test_fill_maze();
    test_dead_end();
    test_result_hold();
    test_random_walk(320);
    idle_off = 1'b1;
    test_random_walk(100);
    test_reach_edge();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (walker_reports.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver: short random stalls, one long hold on request
  initial begin : result_sink
    int n;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!idle_off && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (walker_reports.size() == 0) begin
        report_mismatch("result beat with nothing pending", 1, 0);
      end else begin
        want = walker_reports.pop_front();
        got = out_tdata[13:0];
        if (got.pos_row !== want.pos_row)
          report_mismatch("pos_row", int'(got.pos_row), int'(want.pos_row));
        if (got.pos_col !== want.pos_col)
          report_mismatch("pos_col", int'(got.pos_col), int'(want.pos_col));
        if (got.heading !== want.heading)
          report_mismatch("heading", int'(got.heading), int'(want.heading));
        if (got.status !== want.status)
          report_mismatch("status", int'(got.status), int'(want.status));
        if (got.cell_wall !== want.cell_wall)
          report_mismatch("cell_wall", int'(got.cell_wall), int'(want.cell_wall));
        if (got.cell_visited !== want.cell_visited)
          report_mismatch("cell_visited", int'(got.cell_visited), int'(want.cell_visited));
      end
    end
  end

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[right_hand_maze_walker_core.f]
+incdir+src
src/rhmw_pkg.sv
src/rhmw_ram.sv
src/rhmw_ctrl.sv
src/right_hand_maze_walker_core.sv
tb/tb_right_hand_maze_walker_core.sv
